FILE: hdl/rmca_pkg.sv
// Shared constants, tables and types for the rotation matrix block.
`timescale 1ns / 1ps
package rmca_pkg;

	localparam int DATA_W = 32;
	localparam int ACC_W  = 72;
	localparam int CW     = 36;

	// Operation selector codes
	localparam logic [2:0] FUNC_IDENT = 3'd0;
	localparam logic [2:0] FUNC_ROT_X = 3'd1;
	localparam logic [2:0] FUNC_ROT_Y = 3'd2;
	localparam logic [2:0] FUNC_ROT_Z = 3'd3;
	localparam logic [2:0] FUNC_XFORM = 3'd4;

	// Q5.30 constants
	localparam logic signed [CW-1:0] Q30_ONE     = 36'sd1073741824;
	localparam logic signed [CW-1:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [CW-1:0] Q30_TWO_PI  = 36'sd6746518852;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
	localparam int ATAN_ENTRIES = 30;

	// Arctangent table, truncated Q5.30
	function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;  5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;  5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF; 5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF; 5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F; 5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004; 5'd29: v = 32'h00000002;
			default: v = 32'h0;
		endcase
		return $signed({4'b0, v});
	endfunction

	// Result of a CORDIC run
	typedef struct packed {
		logic                   done;
		logic signed [CW-1:0]   cos_v;
		logic signed [CW-1:0]   sin_v;
	} cordic_res_t;

endpackage

FILE: hdl/rmca_cordic.sv
// Iterative CORDIC: range reduction then one micro-rotation per cycle.
`timescale 1ns / 1ps
module rmca_cordic import rmca_pkg::*; #(
	parameter int CORDIC_STEPS    = 24,
	parameter int COEFF_FRAC_BITS = 30
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DATA_W-1:0] angle,
	output cordic_res_t             res
);

	localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
	localparam int SH    = 30 - COEFF_FRAC_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RED  = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]             state_q;
	logic [4:0]             step_q;
	logic signed [CW-1:0]   a_q, x_q, y_q;
	logic                   neg_q;
	logic signed [CW-1:0]   xs, ys, ax, ay, tk;

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign tk = atan_q30(step_q);

	// Round half up to the coefficient width
	function automatic logic signed [CW-1:0] to_coeff(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = v;
		if (SH > 0) r = (v + (CW'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
		return r;
	endfunction

	assign ax = neg_q ? -x_q : x_q;
	assign ay = neg_q ? -y_q : y_q;

	// Sequence reduction, iterations and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			res.done <= 1'b0;
		end else begin
			res.done <= (state_q == ST_OUT);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q     <= CW'(angle) <<< 3;
						x_q     <= CORDIC_GAIN;
						y_q     <= '0;
						neg_q   <= 1'b0;
						step_q  <= '0;
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					// |a| <= 16*2^30 < 3*2pi, so the wrap passes end
					if (a_q > Q30_PI) a_q <= a_q - Q30_TWO_PI;
					else if (a_q < -Q30_PI) a_q <= a_q + Q30_TWO_PI;
					else if (a_q > Q30_HALF_PI) begin
						a_q <= a_q - Q30_PI; neg_q <= 1'b1; state_q <= ST_ITER;
					end else if (a_q < -Q30_HALF_PI) begin
						a_q <= a_q + Q30_PI; neg_q <= 1'b1; state_q <= ST_ITER;
					end else state_q <= ST_ITER;
				end
				ST_ITER: begin
					if (!a_q[CW-1]) begin
						x_q <= x_q - ys; y_q <= y_q + xs; a_q <= a_q - tk;
					end else begin
						x_q <= x_q + ys; y_q <= y_q - xs; a_q <= a_q + tk;
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(NSTEP - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					res.cos_v <= to_coeff(ax);
					res.sin_v <= to_coeff(ay);
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/rmca_mac.sv
// Shared 32x36 multiplier with registered product and accumulator.
`timescale 1ns / 1ps
module rmca_mac import rmca_pkg::*; (
	input  logic                    clk,
	input  logic                    clr,
	input  logic                    en,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [CW-1:0]    b,
	input  logic                    acc_en,
	output logic signed [ACC_W-1:0] acc_q
);

	logic signed [ACC_W-1:0] prod_s1;

	// Multiply, then accumulate the registered product
	always_ff @(posedge clk) begin
		prod_s1 <= en ? ACC_W'(a) * ACC_W'(b) : '0;
		if (clr) acc_q <= '0;
		else if (acc_en) acc_q <= acc_q + prod_s1;
	end

endmodule

FILE: hdl/rotation_matrix_compose_apply.sv
// Top level: matrix state, sequencer, CORDIC and shared multiply-accumulate.
//
//  channel | dir | beat contents
//  s_axis  | in  | tdata: angle, vec_x, vec_y, vec_z; tuser: func
//  m_axis  | out | tdata: out_x, out_y, out_z; tuser: saturated
//
// Rotations run range reduction, one CORDIC step per cycle, then 9 matrix entries, each
// with three products through the single multiplier followed by an accumulator drain.
// Transforms compute 3 entries, one per output row; identity and unused codes go
// straight to the output beat.
// Reset loads identity and drops any beat. s_axis_tready is low from acceptance until
// the result is taken on m_axis, so m_axis_tready low holds off the next accept.
`timescale 1ns / 1ps
module rotation_matrix_compose_apply import rmca_pkg::*; #(
	parameter int CORDIC_STEPS    = 24,
	parameter int COEFF_FRAC_BITS = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// angle[31:0], vec_x[63:32], vec_y[95:64], vec_z[127:96]
	input  logic [127:0] s_axis_tdata,
	// func[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64]
	output logic [95:0]  m_axis_tdata,
	// saturated[0]
	output logic         m_axis_tuser
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CORD = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< COEFF_FRAC_BITS;

	logic [2:0]               state_q;
	logic [2:0]               func_q;
	logic signed [DATA_W-1:0] vec_q [3];
	logic signed [DATA_W-1:0] mat_q [9];
	logic signed [DATA_W-1:0] new_q [9];
	logic signed [CW-1:0]     cos_q, sin_q;
	logic [3:0]               ent_q;   // output entry i*3+j
	logic [1:0]               k_q;
	logic [1:0]               ph_q;    // 0 issue, 1..2 drain
	logic                     sat_q;
	logic [95:0]              out_q;
	cordic_res_t              cres;

	logic [1:0]               ri, cj;
	logic signed [DATA_W-1:0] mul_a;
	logic signed [CW-1:0]     mul_b;
	logic signed [ACC_W-1:0]  acc;
	logic                     issue, acc_en_q, clr;
	logic signed [ACC_W-1:0]  rnd;
	logic                     hi_ov, lo_ov;

	rmca_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n),
		.start(state_q == ST_IDLE && s_axis_tvalid && s_axis_tuser >= FUNC_ROT_X
			&& s_axis_tuser <= FUNC_ROT_Z),
		.angle(s_axis_tdata[31:0]), .res(cres));

	// Row and column of the entry in progress
	always_comb begin
		ri = (ent_q >= 4'd6) ? 2'd2 : (ent_q >= 4'd3) ? 2'd1 : 2'd0;
		cj = 2'(ent_q - 4'(ri) * 4'd3);
	end

	// Operands: M[i][k] times R[k][j] or v[k]
	always_comb begin
		mul_a = mat_q[4'(ri) * 4'd3 + 4'(k_q)];
		mul_b = '0;
		if (func_q == FUNC_XFORM) mul_b = CW'(vec_q[k_q]);
		else begin
			mul_b = (k_q == cj) ? ONE_C : '0;
			case (func_q)
				FUNC_ROT_X: begin
					if (k_q == 2'd1 && cj == 2'd1) mul_b = cos_q;
					if (k_q == 2'd2 && cj == 2'd2) mul_b = cos_q;
					if (k_q == 2'd2 && cj == 2'd1) mul_b = sin_q;
					if (k_q == 2'd1 && cj == 2'd2) mul_b = -sin_q;
				end
				FUNC_ROT_Y: begin
					if (k_q == 2'd0 && cj == 2'd0) mul_b = cos_q;
					if (k_q == 2'd2 && cj == 2'd2) mul_b = cos_q;
					if (k_q == 2'd0 && cj == 2'd2) mul_b = sin_q;
					if (k_q == 2'd2 && cj == 2'd0) mul_b = -sin_q;
				end
				FUNC_ROT_Z: begin
					if (k_q == 2'd0 && cj == 2'd0) mul_b = cos_q;
					if (k_q == 2'd1 && cj == 2'd1) mul_b = cos_q;
					if (k_q == 2'd1 && cj == 2'd0) mul_b = sin_q;
					if (k_q == 2'd0 && cj == 2'd1) mul_b = -sin_q;
				end
				default: mul_b = '0;
			endcase
		end
	end

	// Clear the accumulator between entries and outside the product phase
	assign issue = (state_q == ST_MAC) && (ph_q == 2'd0);
	assign clr   = (state_q != ST_MAC) || (ph_q == 2'd2);

	rmca_mac u_mac (.clk(clk), .clr(clr), .en(issue), .a(mul_a), .b(mul_b),
		.acc_en(acc_en_q), .acc_q(acc));

	// Round half up, then clamp
	always_comb begin
		if (func_q == FUNC_XFORM) rnd = (acc + (ACC_W'(1) <<< 29)) >>> 30;
		else rnd = (acc + (ACC_W'(1) <<< (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;
		hi_ov = !rnd[ACC_W-1] && (rnd[ACC_W-2:31] != '0);
		lo_ov = rnd[ACC_W-1] && (rnd[ACC_W-2:31] != '1);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = out_q;
	assign m_axis_tuser  = sat_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			acc_en_q <= 1'b0;
			ent_q    <= '0;
			k_q      <= '0;
			ph_q     <= '0;
			sat_q    <= 1'b0;
			for (int n = 0; n < 9; n++)
				mat_q[n] <= (n % 4 == 0) ? DATA_W'(32'sd1073741824) : '0;
		end else begin
			acc_en_q <= issue;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						func_q   <= s_axis_tuser;
						vec_q[0] <= s_axis_tdata[63:32];
						vec_q[1] <= s_axis_tdata[95:64];
						vec_q[2] <= s_axis_tdata[127:96];
						ent_q <= '0; k_q <= '0; ph_q <= '0; sat_q <= 1'b0;
						out_q <= '0;
						if (s_axis_tuser == FUNC_IDENT) begin
							for (int n = 0; n < 9; n++)
								mat_q[n] <= (n % 4 == 0) ? DATA_W'(32'sd1073741824) : '0;
							state_q <= ST_OUT;
						end else if (s_axis_tuser == FUNC_XFORM) state_q <= ST_MAC;
						else if (s_axis_tuser <= FUNC_ROT_Z) state_q <= ST_CORD;
						else state_q <= ST_OUT;
					end
				end
				ST_CORD: begin
					if (cres.done) begin
						cos_q <= cres.cos_v; sin_q <= cres.sin_v; state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					// issue three products, then wait for the accumulator to drain
					if (ph_q == 2'd0) begin
						k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
						if (k_q == 2'd2) ph_q <= 2'd1;
					end else if (ph_q == 2'd1) ph_q <= 2'd2;
					else begin
						ph_q <= 2'd0;
						if (func_q == FUNC_XFORM) begin
							out_q[ri*32 +: 32] <= hi_ov ? 32'h7FFFFFFF : lo_ov ? 32'h80000000
								: rnd[31:0];
							if (hi_ov || lo_ov) sat_q <= 1'b1;
						end else
							new_q[ent_q] <= hi_ov ? 32'sh7FFFFFFF : lo_ov ? 32'sh80000000
								: rnd[31:0];
						// transforms step one row at a time
						ent_q <= ent_q + ((func_q == FUNC_XFORM) ? 4'd3 : 4'd1);
						if (func_q == FUNC_XFORM && ent_q == 4'd6) state_q <= ST_DONE;
						if (func_q != FUNC_XFORM && ent_q == 4'd8) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (func_q != FUNC_XFORM)
						for (int n = 0; n < 9; n++) mat_q[n] <= new_q[n];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_axis_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: dv/tb_rotation_matrix_compose_apply.sv
// Testbench for the rotation matrix block: streams operations, predicts each result, compares.
`timescale 1ns / 1ps
module tb_rotation_matrix_compose_apply;
	import rmca_pkg::*;

	localparam int STEPS     = 24;
	localparam int FRAC      = 30;
	localparam int N_RANDOM  = 850;
	localparam int CYCLE_CAP = 1000000;

	localparam logic [2:0] FUNC_SPARE5 = 3'd5;
	localparam logic [2:0] FUNC_SPARE6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE7 = 3'd7;

	localparam longint W_ONE     = 64'sd1073741824;
	localparam longint W_PI      = 64'sd3373259426;
	localparam longint W_HALF_PI = 64'sd1686629713;
	localparam longint W_TWO_PI  = 64'sd6746518852;
	localparam longint W_GAIN    = 64'sd652032874;

	typedef struct packed {
		logic       saturated;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} vec_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;
	logic         m_axis_tuser;

	rotation_matrix_compose_apply #(
		.CORDIC_STEPS(STEPS),
		.COEFF_FRAC_BITS(FRAC)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	longint      matrix_q30[9];
	vec_result_t pending_results[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          sat_seen = 0;
	int          cycle_count = 0;
	bit          idle_enabled;

	// Clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("rotation_matrix_compose_apply verification failed");
			$finish;
		end
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_i32(longint v, ref bit hit);
		if (v > 64'sd2147483647) begin
			hit = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			hit = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint round_coeff(longint q30);
		int sh;
		sh = 30 - FRAC;
		if (sh == 0) return q30;
		return floor_shift(q30 + (64'sd1 <<< (sh - 1)), sh);
	endfunction

	// CORDIC sine and cosine of a Q4.27 angle
	task automatic sincos_q30(input logic signed [31:0] ang, output longint s, output longint c);
		longint a, x, y, t;
		bit     flip;
		a = longint'(ang) * 8;
		x = W_GAIN;
		y = 0;
		flip = 1'b0;
		while (a > W_PI) a -= W_TWO_PI;
		while (a < -W_PI) a += W_TWO_PI;
		if (a > W_HALF_PI) begin
			a -= W_PI;
			flip = 1'b1;
		end else if (a < -W_HALF_PI) begin
			a += W_PI;
			flip = 1'b1;
		end
		for (int i = 0; i < STEPS && i < 30; i++) begin
			if (a >= 0) begin
				t = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				a -= longint'(atan_q30(i[4:0]));
			end else begin
				t = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				a += longint'(atan_q30(i[4:0]));
			end
			x = t;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = round_coeff(x);
		s = round_coeff(y);
	endtask

	task automatic load_identity();
		for (int i = 0; i < 9; i++) matrix_q30[i] = (i % 4 == 0) ? W_ONE : 0;
	endtask

	// Advance the matrix model and return the expected beat
	task automatic predict_beat(input logic [2:0] fn, input logic signed [31:0] ang,
			input logic signed [31:0] vx, input logic signed [31:0] vy,
			input logic signed [31:0] vz, output vec_result_t r);
		longint rot[9], nxt[9], s, c, acc, hi, lo, p, one, v[3];
		bit     hit, dummy;
		r = '0;
		hit = 1'b0;
		dummy = 1'b0;
		one = 64'sd1 <<< FRAC;
		case (fn)
			FUNC_IDENT: load_identity();
			FUNC_ROT_X, FUNC_ROT_Y, FUNC_ROT_Z: begin
				sincos_q30(ang, s, c);
				foreach (rot[i]) rot[i] = 0;
				rot[0] = one; rot[4] = one; rot[8] = one;
				if (fn == FUNC_ROT_X) begin
					rot[4] = c; rot[8] = c; rot[7] = s; rot[5] = -s;
				end else if (fn == FUNC_ROT_Y) begin
					rot[0] = c; rot[8] = c; rot[2] = s; rot[6] = -s;
				end else begin
					rot[0] = c; rot[4] = c; rot[3] = s; rot[1] = -s;
				end
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						acc = 0;
						for (int k = 0; k < 3; k++) acc += matrix_q30[i*3+k] * rot[k*3+j];
						acc = floor_shift(acc + (64'sd1 <<< (FRAC - 1)), FRAC);
						nxt[i*3+j] = clamp_i32(acc, dummy);
					end
				matrix_q30 = nxt;
			end
			FUNC_XFORM: begin
				v[0] = vx; v[1] = vy; v[2] = vz;
				for (int i = 0; i < 3; i++) begin
					hi = 0;
					lo = 0;
					for (int j = 0; j < 3; j++) begin
						p = matrix_q30[i*3+j] * v[j];
						hi += floor_shift(p, 30);
						lo += p & 64'h3FFF_FFFF;
					end
					acc = clamp_i32(hi + floor_shift(lo + (64'sd1 <<< 29), 30), hit);
					if (i == 0) r.x = acc[31:0];
					else if (i == 1) r.y = acc[31:0];
					else r.z = acc[31:0];
				end
				r.saturated = hit;
			end
			default: ;
		endcase
	endtask

	// Send one beat, sometimes with a random gap ahead of it
	task automatic send_op(input logic [2:0] fn, input logic signed [31:0] ang,
			input logic signed [31:0] vx, input logic signed [31:0] vy,
			input logic signed [31:0] vz);
		vec_result_t r;
		int gap;
		if (idle_enabled && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 11);
			repeat (gap) @(posedge clk);
		end
		predict_beat(fn, ang, vx, vy, vz, r);
		pending_results.push_back(r);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {vz, vy, vx, ang};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Receiver stalls in bursts
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_enabled && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		vec_result_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata};
			results_seen++;
			if (got.saturated) sat_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: want x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
							results_seen, want.x, want.y, want.z, want.saturated,
							got.x, got.y, got.z, got.saturated);
				end
			end
		end
	end

	function automatic logic signed [31:0] any_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [31:0] any_angle();
		if ($urandom_range(0, 4) == 0) return any_word();
		return $signed($urandom_range(0, 32'h6487_ED51)) - 32'sh3243_F6A8;
	endfunction

	task automatic test_directed_extremes();
		send_op(FUNC_XFORM, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000);
		send_op(FUNC_ROT_X, 32'sh7FFF_FFFF, 0, 0, 0);
		send_op(FUNC_ROT_Y, 32'sh8000_0000, 0, 0, 0);
		send_op(FUNC_ROT_Z, 32'sh0C90_FDAA, 0, 0, 0);
		send_op(FUNC_XFORM, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_op(FUNC_XFORM, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_op(FUNC_SPARE5, 32'shFFFF_FFFF, -1, -1, -1);
		send_op(FUNC_SPARE6, 0, 0, 0, 0);
		send_op(FUNC_SPARE7, 32'sh1234_5678, 1, 2, 3);
		send_op(FUNC_XFORM, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
		send_op(FUNC_IDENT, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
		// Quarter turn about X and half turns about Y and Z, then one three-angle build
		send_op(FUNC_ROT_X, 32'sh0C90_FDAA, 0, 0, 0);
		send_op(FUNC_ROT_Y, 32'sh1921_FB54, 0, 0, 0);
		send_op(FUNC_ROT_Z, -32'sh1921_FB54, 0, 0, 0);
		send_op(FUNC_XFORM, 0, 32'sh0001_0000, -32'sh0001_0000, 32'sh7FFF_FFFF);
		send_op(FUNC_IDENT, 0, 0, 0, 0);
		send_op(FUNC_ROT_Z, 32'sh0860_A91C, 0, 0, 0);
		send_op(FUNC_ROT_Y, -32'sh0430_548E, 0, 0, 0);
		send_op(FUNC_ROT_X, 32'sh1000_0000, 0, 0, 0);
		send_op(FUNC_XFORM, 0, 32'sh0100_0000, 32'shFF00_0000, 32'sh0000_8000);
	endtask

	task automatic test_random_sequences(input int count);
		int sent, r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 19);
			if (r < 6) begin
				// three-angle build, then a few transforms
				send_op(FUNC_IDENT, any_word(), any_word(), any_word(), any_word());
				send_op(FUNC_ROT_Z, any_angle(), 0, 0, 0);
				send_op(FUNC_ROT_Y, any_angle(), 0, 0, 0);
				send_op(FUNC_ROT_X, any_angle(), 0, 0, 0);
				repeat (2) send_op(FUNC_XFORM, any_word(), any_word(), any_word(), any_word());
				sent += 6;
			end else if (r < 18) begin
				send_op(3'($urandom_range(1, 4)), any_angle(), any_word(), any_word(),
					any_word());
				sent++;
			end else begin
				send_op(3'($urandom_range(0, 7)), any_word(), any_word(), any_word(),
					any_word());
				sent++;
			end
		end
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		idle_enabled = 1'b1;
		load_identity();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_random_sequences(N_RANDOM * 4 / 5);
		// Run the tail with no idling
		idle_enabled = 1'b0;
		test_random_sequences(N_RANDOM / 5);
		s_axis_tvalid <= 1'b0;

		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		$display("covered %0d result beats, %0d with clamped components, across identity,",
			results_seen, sat_seen);
		$display("axis rotations, transforms and spare codes");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("rotation_matrix_compose_apply verification clean");
		else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
			$display("rotation_matrix_compose_apply verification failed");
		end
		$finish;
	end

endmodule
